// ===== rtl/rspf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspf_pkg
// Shared types, codes and constants of the ranging sensor poll frame engine.
// ----------------------------------------------------------------------------
package rspf_pkg;

	// parameter defaults
	localparam int SENSOR_COUNT_DEF   = 4;
	localparam int RX_FRAME_BYTES_DEF = 256;

	// fixed widths
	localparam int CNT_W   = 9;
	localparam int SLOT_W  = 4;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int OUT_W   = 32;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;

	localparam logic [3:0] REQ_LAST_IDX = 4'd8;
	localparam logic [7:0] REQ_LEN_BYTE = 8'd2;
	localparam logic [8:0] MIN_FRAME    = 9'd8;
	localparam logic [8:0] LEN_OVERHEAD = 9'd10;

	// register reset values
	localparam logic [7:0]  HOST_HDR_RST   = 8'h51;
	localparam logic [7:0]  CLIENT_HDR_RST = 8'h55;
	localparam logic [7:0]  SENS_TYPE_RST  = 8'h0C;
	localparam logic [15:0] ID_BASE_RST    = 16'h2201;
	localparam logic [7:0]  DIST_REG_RST   = 8'h00;

	typedef enum logic [2:0] {
		REG_HOST_HDR   = 3'd0,
		REG_CLIENT_HDR = 3'd1,
		REG_SENS_TYPE  = 3'd2,
		REG_ID_BASE    = 3'd3,
		REG_DIST_REG   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_RX   = 2'd0,
		KIND_EOF  = 2'd1,
		KIND_POLL = 2'd2
	} in_kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_HEADER = 3'd2,
		ST_TYPE   = 3'd3,
		ST_RW     = 3'd4,
		ST_SUM    = 3'd5,
		ST_LENGTH = 3'd6
	} status_t;

	localparam logic OUT_REQ    = 1'b0;
	localparam logic OUT_REPORT = 1'b1;

	typedef struct packed {
		logic [7:0]  host_hdr;
		logic [7:0]  client_hdr;
		logic [7:0]  sens_type;
		logic [15:0] id_base;
		logic [7:0]  dist_reg;
	} cfg_t;

	// one queued job for the back end: a poll or a finished report
	typedef struct packed {
		logic              is_poll;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       dist_mm;
		logic              dist_ok;
	} job_t;

	// request frame byte idx for a given slot
	function automatic logic [7:0] req_byte(cfg_t c, logic [3:0] idx, logic [SLOT_W-1:0] slot);
		logic [15:0] id;
		logic [15:0] sum;
		logic [7:0]  b;
		id  = c.id_base + {{(16-SLOT_W){1'b0}}, slot};
		sum = {8'd0, c.host_hdr} + {8'd0, c.sens_type} + {8'd0, id[15:8]}
			+ {8'd0, id[7:0]} + {8'd0, c.dist_reg} + {8'd0, REQ_LEN_BYTE};
		case (idx)
			4'd0: b = c.host_hdr;
			4'd1: b = c.sens_type;
			4'd2: b = id[15:8];
			4'd3: b = id[7:0];
			4'd4: b = 8'd0;
			4'd5: b = c.dist_reg;
			4'd6: b = REQ_LEN_BYTE;
			4'd7: b = sum[15:8];
			4'd8: b = sum[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/rspf_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspf_cfg
// APB register file holding headers, sensor type, id base and register code.
// ----------------------------------------------------------------------------
module rspf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rspf_pkg::ADDR_W-1:0] paddr,
	input  logic [rspf_pkg::DATA_W-1:0] pwdata,
	output logic [rspf_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rspf_pkg::cfg_t             cfg
);
	import rspf_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.host_hdr   <= HOST_HDR_RST;
			cfg_q.client_hdr <= CLIENT_HDR_RST;
			cfg_q.sens_type  <= SENS_TYPE_RST;
			cfg_q.id_base    <= ID_BASE_RST;
			cfg_q.dist_reg   <= DIST_REG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HOST_HDR:   cfg_q.host_hdr   <= pwdata[7:0];
				REG_CLIENT_HDR: cfg_q.client_hdr <= pwdata[7:0];
				REG_SENS_TYPE:  cfg_q.sens_type  <= pwdata[7:0];
				REG_ID_BASE:    cfg_q.id_base    <= pwdata[15:0];
				REG_DIST_REG:   cfg_q.dist_reg   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HOST_HDR:   prdata = {24'd0, cfg_q.host_hdr};
			REG_CLIENT_HDR: prdata = {24'd0, cfg_q.client_hdr};
			REG_SENS_TYPE:  prdata = {24'd0, cfg_q.sens_type};
			REG_ID_BASE:    prdata = {16'd0, cfg_q.id_base};
			REG_DIST_REG:   prdata = {24'd0, cfg_q.dist_reg};
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rspf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspf_front
// Accepts input items, collects reply bytes, checks frames and queues jobs.
// ----------------------------------------------------------------------------
module rspf_front #(
	parameter int SENSOR_COUNT   = rspf_pkg::SENSOR_COUNT_DEF,
	parameter int RX_FRAME_BYTES = rspf_pkg::RX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rspf_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_kind,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                q_push,
	output rspf_pkg::job_t      q_job
);
	import rspf_pkg::*;

	localparam logic [CNT_W-1:0]  FRAME_MAX = CNT_W'(RX_FRAME_BYTES);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SENSOR_COUNT - 1);

	logic [CNT_W-1:0]  byte_count_q;
	logic [15:0]       run_sum_q;
	logic [7:0]        kept_q [7];
	logic [7:0]        prev_byte_q;
	logic [7:0]        last_byte_q;
	logic [SLOT_W-1:0] next_slot_q;

	logic              take;
	in_kind_t          kind;
	logic [CNT_W-1:0]  pos;
	logic [15:0]       sum_base;
	logic [15:0]       body_sum;
	logic [SLOT_W-1:0] rep_slot;
	status_t           st;
	logic              dist_ok;

	assign in_ready = ~q_full;
	assign take     = in_valid & in_ready;
	assign kind     = in_kind_t'(in_kind);

	// an overflowing frame restarts at byte zero
	assign pos      = (byte_count_q >= FRAME_MAX) ? '0 : byte_count_q;
	assign sum_base = (byte_count_q >= FRAME_MAX) ? 16'd0 : run_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			run_sum_q    <= '0;
			for (int i = 0; i < 7; i++) kept_q[i] <= '0;
			prev_byte_q  <= '0;
			last_byte_q  <= '0;
			next_slot_q  <= '0;
		end else if (take) begin
			unique case (kind)
				KIND_RX: begin
					case (pos)
						9'd0: kept_q[0] <= in_byte;
						9'd1: kept_q[1] <= in_byte;
						9'd4: kept_q[2] <= in_byte;
						9'd6: kept_q[3] <= in_byte;
						9'd7: kept_q[4] <= in_byte;
						9'd8: kept_q[5] <= in_byte;
						9'd9: kept_q[6] <= in_byte;
						default: ;
					endcase
					prev_byte_q  <= last_byte_q;
					last_byte_q  <= in_byte;
					run_sum_q    <= sum_base + {8'd0, in_byte};
					byte_count_q <= pos + 1'b1;
				end
				KIND_EOF: begin
					byte_count_q <= '0;
					run_sum_q    <= '0;
				end
				KIND_POLL: begin
					next_slot_q <= (next_slot_q >= SLOT_LAST) ? '0 : next_slot_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign body_sum = run_sum_q - {8'd0, prev_byte_q} - {8'd0, last_byte_q};
	assign rep_slot = (next_slot_q == '0) ? SLOT_LAST : next_slot_q - 1'b1;

	always_comb begin
		st      = ST_OK;
		dist_ok = 1'b0;
		if (byte_count_q < MIN_FRAME) begin
			st = ST_SHORT;
		end else if (kept_q[0] != cfg.client_hdr) begin
			st = ST_HEADER;
		end else if (kept_q[1] != cfg.sens_type) begin
			st = ST_TYPE;
		end else if (kept_q[2] > 8'd1) begin
			st = ST_RW;
		end else if (body_sum != {prev_byte_q, last_byte_q}) begin
			st = ST_SUM;
		end else if ({1'b0, kept_q[4]} + LEN_OVERHEAD != byte_count_q) begin
			st = ST_LENGTH;
		end else begin
			dist_ok = (kept_q[2] == 8'd0) && (kept_q[3] == cfg.dist_reg);
		end
	end

	assign q_push          = take & ((kind == KIND_EOF) | (kind == KIND_POLL));
	assign q_job.is_poll   = (kind == KIND_POLL);
	assign q_job.status    = (kind == KIND_POLL) ? ST_OK : st;
	assign q_job.slot      = (kind == KIND_POLL) ? next_slot_q : rep_slot;
	assign q_job.dist_mm   = (kind != KIND_POLL && dist_ok) ? {kept_q[5], kept_q[6]} : 16'd0;
	assign q_job.dist_ok   = (kind != KIND_POLL) & dist_ok;

endmodule

// ===== rtl/rspf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspf_fifo
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module rspf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rspf_pkg::job_t push_job,
	input  logic           pop,
	output rspf_pkg::job_t head_job,
	output logic           empty,
	output logic           full
);
	import rspf_pkg::*;

	job_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_job = slots_q[rd_ptr_q];
	assign do_pop   = pop & ~empty;

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push & ~do_pop) count_q <= count_q + 1'b1;
			else if (do_pop & ~push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/rspf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspf_back
// Expands poll jobs into request bytes, passes reports on and drives the output register.
// ----------------------------------------------------------------------------
module rspf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rspf_pkg::cfg_t               cfg,
	input  logic                         q_empty,
	input  rspf_pkg::job_t               q_job,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rspf_pkg::OUT_W-1:0]   out_data,
	output logic                         out_user,
	output logic                         out_last
);
	import rspf_pkg::*;

	logic              busy_q;
	logic [3:0]        idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic              valid_q;
	logic [OUT_W-1:0]  data_q;
	logic              user_q;
	logic              last_q;
	logic              adv;

	assign adv   = ~valid_q | out_ready;
	assign q_pop = adv & ~busy_q & ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				valid_q <= 1'b1;
				if (idx_q == REQ_LAST_IDX) busy_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				if (q_job.is_poll) begin
					busy_q <= 1'b1;
					idx_q  <= 4'd1;
					slot_q <= q_job.slot;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload: tx_byte, status, slot, distance, distance valid
	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				data_q <= {1'b0, 16'd0, slot_q, ST_OK, req_byte(cfg, idx_q, slot_q)};
				user_q <= OUT_REQ;
				last_q <= (idx_q == REQ_LAST_IDX);
			end else if (q_job.is_poll) begin
				data_q <= {1'b0, 16'd0, q_job.slot, ST_OK, req_byte(cfg, 4'd0, q_job.slot)};
				user_q <= OUT_REQ;
				last_q <= 1'b0;
			end else begin
				data_q <= {q_job.dist_ok, q_job.dist_mm, q_job.slot, q_job.status, 8'd0};
				user_q <= OUT_REPORT;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

endmodule

// ===== rtl/ranging_sensor_poll_frame_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranging_sensor_poll_frame_engine
// Polls ranging sensors with checksummed read requests and checks replies.
// ----------------------------------------------------------------------------
// The input side takes one item per clock whenever the four-entry job queue
// has room. Received bytes update the frame count, running sum and captured
// header bytes in the cycle they arrive and give no output. An end-of-frame
// item is checked in its accept cycle and queued as one report transfer; a
// poll item is queued and expanded by the back end into nine request-byte
// transfers, one per clock while the output is not stalled. Output transfers
// leave a registered stage one per cycle when m_axis_tready allows, and the
// queue absorbs up to four pending polls or reports while the input keeps running.
// First output follows an accepted item through the job queue and the output register.
module ranging_sensor_poll_frame_engine #(
	parameter int SENSOR_COUNT   = rspf_pkg::SENSOR_COUNT_DEF,
	parameter int RX_FRAME_BYTES = rspf_pkg::RX_FRAME_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rspf_pkg::ADDR_W-1:0]  paddr,
	input  logic [rspf_pkg::DATA_W-1:0]  pwdata,
	output logic [rspf_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]                   s_axis_tuser,  // [1:0] kind
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [7:0] tx_byte, [10:8] status, [14:11] sensor_slot, [30:15] distance_mm,
	// [31] distance_valid
	output logic [rspf_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic                         m_axis_tuser,  // [0] out_kind
	output logic                         m_axis_tlast
);
	import rspf_pkg::*;

	cfg_t cfg;
	job_t push_job;
	job_t head_job;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;

	rspf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rspf_front #(
		.SENSOR_COUNT   (SENSOR_COUNT),
		.RX_FRAME_BYTES (RX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	rspf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	rspf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
